### rtl/core/prmr_pkg.sv
// Package for the range-mapped Park-Miller generator.
// Holds the microcode types, datapath constants and the status record.
// No dependencies.
`timescale 1ns / 1ps

package prmr_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned DrawW     = 31;
  localparam int unsigned ProdW     = 47;
  localparam int unsigned DvdW      = 36;
  localparam int unsigned DivCntW   = 6;
  localparam int unsigned ResCntW   = 5;
  localparam int unsigned PcW       = 5;
  localparam int unsigned UcodeLen  = 20;

  localparam logic [14:0]        PmMult      = 15'd16807;
  localparam logic [DrawW-1:0]   PmMod       = 31'h7fff_ffff;
  localparam logic [DataW-1:0]   PmZeroSub   = 32'd20080806;
  localparam logic [DataW-1:0]   PmResetState = 32'h2008_0806;
  localparam logic [DataW-1:0]   PmSmallLimit = 32'h07ff_ffff;
  localparam logic [DataW-1:0]   PmExactSpan = 32'h7fff_fffe;
  localparam logic [DataW-1:0]   PmFullSpan  = 32'hffff_ffff;
  localparam logic [ResCntW-1:0] PmFillCount = 5'd30;
  localparam logic [ResCntW-1:0] PmTakeWide  = 5'd6;
  localparam logic [ResCntW-1:0] PmTakeFull  = 5'd2;
  localparam logic [DivCntW-1:0] PmDivSteps  = 6'd36;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_LOAD,
    UOP_SEED,
    UOP_MUL,
    UOP_FOLD_MAIN,
    UOP_FOLD_FILL,
    UOP_TAKE6,
    UOP_SET_SMALL,
    UOP_DIV_STEP,
    UOP_OFF_REM,
    UOP_TAKE2,
    UOP_OFF_RAW,
    UOP_EMIT
  } uop_e;

  typedef enum logic [3:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_REQ,
    COND_SEED,
    COND_EXACT,
    COND_FULL,
    COND_SMALL,
    COND_HAS6,
    COND_HAS2,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    uop_e           uop;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           last;
  } ctrl_t;

  typedef struct packed {
    logic seed;
    logic exact;
    logic full;
    logic small_span;
    logic has6;
    logic has2;
    logic div_more;
    logic out_busy;
  } status_t;

endpackage

### rtl/core/prmr_ucode_rom.sv
// Microcode store for the range-mapped Park-Miller generator.
// Maps a step number to its control word; depends on prmr_pkg.
`timescale 1ns / 1ps

module prmr_ucode_rom (
  input  logic [prmr_pkg::PcW-1:0] pc_i,
  output prmr_pkg::ctrl_t          ctrl_o
);
  import prmr_pkg::*;

  localparam logic [PcW-1:0] StIdle   = 5'd0;
  localparam logic [PcW-1:0] StWide   = 5'd9;
  localparam logic [PcW-1:0] StSmall  = 5'd10;
  localparam logic [PcW-1:0] StDiv    = 5'd11;
  localparam logic [PcW-1:0] StFull   = 5'd13;
  localparam logic [PcW-1:0] StTake2  = 5'd16;
  localparam logic [PcW-1:0] StRaw    = 5'd17;
  localparam logic [PcW-1:0] StEmit   = 5'd18;
  localparam logic [PcW-1:0] StSeed   = 5'd19;

  always_comb begin
    unique case (pc_i)
      5'd0:  ctrl_o = '{UOP_LOAD,      COND_NO_REQ,   StIdle,  1'b0};
      5'd1:  ctrl_o = '{UOP_NOP,       COND_SEED,     StSeed,  1'b0};
      5'd2:  ctrl_o = '{UOP_MUL,       COND_NEVER,    StIdle,  1'b0};
      5'd3:  ctrl_o = '{UOP_FOLD_MAIN, COND_EXACT,    StRaw,   1'b0};
      5'd4:  ctrl_o = '{UOP_NOP,       COND_FULL,     StFull,  1'b0};
      5'd5:  ctrl_o = '{UOP_NOP,       COND_SMALL,    StSmall, 1'b0};
      5'd6:  ctrl_o = '{UOP_NOP,       COND_HAS6,     StWide,  1'b0};
      5'd7:  ctrl_o = '{UOP_MUL,       COND_NEVER,    StIdle,  1'b0};
      5'd8:  ctrl_o = '{UOP_FOLD_FILL, COND_NEVER,    StIdle,  1'b0};
      5'd9:  ctrl_o = '{UOP_TAKE6,     COND_ALWAYS,   StDiv,   1'b0};
      5'd10: ctrl_o = '{UOP_SET_SMALL, COND_NEVER,    StIdle,  1'b0};
      5'd11: ctrl_o = '{UOP_DIV_STEP,  COND_DIV_MORE, StDiv,   1'b0};
      5'd12: ctrl_o = '{UOP_OFF_REM,   COND_ALWAYS,   StEmit,  1'b0};
      5'd13: ctrl_o = '{UOP_NOP,       COND_HAS2,     StTake2, 1'b0};
      5'd14: ctrl_o = '{UOP_MUL,       COND_NEVER,    StIdle,  1'b0};
      5'd15: ctrl_o = '{UOP_FOLD_FILL, COND_NEVER,    StIdle,  1'b0};
      5'd16: ctrl_o = '{UOP_TAKE2,     COND_ALWAYS,   StEmit,  1'b0};
      5'd17: ctrl_o = '{UOP_OFF_RAW,   COND_NEVER,    StIdle,  1'b0};
      5'd18: ctrl_o = '{UOP_EMIT,      COND_OUT_BUSY, StEmit,  1'b1};
      5'd19: ctrl_o = '{UOP_SEED,      COND_ALWAYS,   StIdle,  1'b0};
      default: ctrl_o = '{UOP_NOP,     COND_ALWAYS,   StIdle,  1'b0};
    endcase
  end

endmodule

### rtl/core/prmr_datapath.sv
// Datapath of the range-mapped Park-Miller generator: generator state,
// bit reservoir, multiply-fold unit, bit-serial divider and output register.
// Driven by control words from prmr_ucode_rom; depends on prmr_pkg.
`timescale 1ns / 1ps

module prmr_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  prmr_pkg::uop_e               uop_i,
  input  logic                         load_i,
  input  logic                         op_i,
  input  logic [prmr_pkg::DataW-1:0]   range_first_i,
  input  logic [prmr_pkg::DataW-1:0]   range_last_i,
  input  logic [prmr_pkg::DataW-1:0]   seed_value_i,
  input  logic                         out_ready_i,
  output prmr_pkg::status_t            status_o,
  output logic                         out_valid_o,
  output logic [prmr_pkg::DataW-1:0]   random_value_o
);
  import prmr_pkg::*;

  logic [DataW-1:0]   state_q;
  logic [DrawW-1:0]   res_q;
  logic [ResCntW-1:0] res_cnt_q;
  logic               op_q;
  logic [DataW-1:0]   first_q;
  logic [DataW-1:0]   span_q;
  logic [DataW-1:0]   seed_q;
  logic [DrawW-1:0]   draw_q;
  logic [ProdW-1:0]   prod_q;
  logic [DvdW-1:0]    dvd_q;
  logic [DataW-1:0]   rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [DataW-1:0]   off_q;
  logic               out_valid_q;
  logic [DataW-1:0]   out_value_q;

  logic [DataW-1:0]   mul_src;
  logic [ProdW-1:0]   prod_d;
  logic [DataW-1:0]   fold_sum;
  logic [DrawW-1:0]   fold_d;
  logic [DataW-1:0]   divisor;
  logic [DataW:0]     rem_sh;
  logic [DataW:0]     rem_sub;
  logic [DataW-1:0]   rem_d;
  logic               out_busy;
  logic               emit;

  assign mul_src  = (state_q == '0) ? PmZeroSub : state_q;
  assign prod_d   = ProdW'(mul_src) * ProdW'(PmMult);
  assign fold_sum = DataW'(prod_q[DrawW-1:0]) + DataW'(prod_q[ProdW-1:DrawW]);
  assign fold_d   = (fold_sum >= DataW'(PmMod)) ? DrawW'(fold_sum - DataW'(PmMod))
                                                : fold_sum[DrawW-1:0];

  assign divisor  = span_q + DataW'(1);
  assign rem_sh   = {rem_q, dvd_q[DvdW-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign rem_d    = (rem_sh >= {1'b0, divisor}) ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];

  assign out_busy = out_valid_q && !out_ready_i;
  assign emit     = (uop_i == UOP_EMIT) && !out_busy;

  assign status_o.seed       = op_q;
  assign status_o.exact      = (span_q == PmExactSpan);
  assign status_o.full       = (span_q == PmFullSpan);
  assign status_o.small_span = (span_q < PmSmallLimit);
  assign status_o.has6       = (res_cnt_q >= PmTakeWide);
  assign status_o.has2       = (res_cnt_q >= PmTakeFull);
  assign status_o.div_more   = (div_cnt_q != DivCntW'(1));
  assign status_o.out_busy   = out_busy;

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PmResetState;
      res_q       <= '0;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (uop_i)
        UOP_SEED: begin
          state_q   <= seed_q;
          res_q     <= '0;
          res_cnt_q <= '0;
        end
        UOP_FOLD_MAIN: begin
          state_q <= DataW'(fold_d);
        end
        UOP_FOLD_FILL: begin
          state_q   <= DataW'(fold_d);
          res_q     <= fold_d;
          res_cnt_q <= PmFillCount;
        end
        UOP_TAKE6: begin
          res_q     <= res_q >> PmTakeWide;
          res_cnt_q <= res_cnt_q - PmTakeWide;
        end
        UOP_TAKE2: begin
          res_q     <= res_q >> PmTakeFull;
          res_cnt_q <= res_cnt_q - PmTakeFull;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q    <= op_i;
      first_q <= range_first_i;
      span_q  <= range_last_i - range_first_i;
      seed_q  <= seed_value_i;
    end
    if (emit) begin
      out_value_q <= off_q + first_q;
    end
    case (uop_i)
      UOP_MUL: begin
        prod_q <= prod_d;
      end
      UOP_FOLD_MAIN: begin
        draw_q <= fold_d;
      end
      UOP_TAKE6: begin
        dvd_q     <= {res_q[5:0], draw_q[DrawW-1:1]};
        rem_q     <= '0;
        div_cnt_q <= PmDivSteps;
      end
      UOP_SET_SMALL: begin
        dvd_q     <= {6'b0, draw_q[DrawW-1:1]};
        rem_q     <= '0;
        div_cnt_q <= PmDivSteps;
      end
      UOP_DIV_STEP: begin
        dvd_q     <= {dvd_q[DvdW-2:0], 1'b0};
        rem_q     <= rem_d;
        div_cnt_q <= div_cnt_q - DivCntW'(1);
      end
      UOP_OFF_REM: begin
        off_q <= rem_q;
      end
      UOP_TAKE2: begin
        off_q <= {res_q[1:0], draw_q[DrawW-1:1]};
      end
      UOP_OFF_RAW: begin
        off_q <= DataW'(draw_q);
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_res_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= PmFillCount)
    else $error("reservoir count above fill level");

  a_fold_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop_i == UOP_FOLD_MAIN) |=> (state_q < DataW'(PmMod)))
    else $error("folded draw not reduced below the modulus");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop_i == UOP_DIV_STEP) |-> (rem_q < divisor))
    else $error("partial remainder not below divisor");
`endif

endmodule

### rtl/core/park_miller_range_rng_unit.sv
// Range-mapped Park-Miller generator, top level: step counter and jump
// logic around prmr_ucode_rom and prmr_datapath; depends on prmr_pkg.
//
// Usage. A request enters on in_valid_i/in_ready_o. With op_i low it draws
// a number in [range_first_i, range_last_i] and gives one result on
// out_valid_o/out_ready_i; with op_i high it loads seed_value_i as the
// generator state, empties the bit reservoir and gives no result.
// A request is taken only while the sequencer sits at its idle step, so one
// request is worked on at a time. Spans other than the exact and the full
// span run through the 36 one-bit steps of the shared restoring divider.
// A seed request returns to idle once the new state is loaded. The finished
// result sits in an output register, so the next request is taken while it
// waits; when the receiver stalls, the following result holds at the emit
// step until the register is free.
// After reset the state is 0x20080806 and the reservoir is empty.
`timescale 1ns / 1ps

module park_miller_range_rng_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [prmr_pkg::DataW-1:0] range_first_i,
  input  logic [prmr_pkg::DataW-1:0] range_last_i,
  input  logic [prmr_pkg::DataW-1:0] seed_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [prmr_pkg::DataW-1:0] random_value_o
);
  import prmr_pkg::*;

  logic [PcW-1:0] pc_q;
  logic [PcW-1:0] pc_d;
  ctrl_t          ctrl;
  status_t        status;
  logic           cond_true;
  logic           in_fire;

  assign in_ready_o = (pc_q == '0);
  assign in_fire    = in_valid_i && in_ready_o;

  prmr_ucode_rom u_rom (
    .pc_i   (pc_q),
    .ctrl_o (ctrl)
  );

  prmr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .uop_i          (ctrl.uop),
    .load_i         (in_fire),
    .op_i           (op_i),
    .range_first_i  (range_first_i),
    .range_last_i   (range_last_i),
    .seed_value_i   (seed_value_i),
    .out_ready_i    (out_ready_i),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .random_value_o (random_value_o)
  );

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_NEVER:    cond_true = 1'b0;
      COND_NO_REQ:   cond_true = !in_valid_i;
      COND_SEED:     cond_true = status.seed;
      COND_EXACT:    cond_true = status.exact;
      COND_FULL:     cond_true = status.full;
      COND_SMALL:    cond_true = status.small_span;
      COND_HAS6:     cond_true = status.has6;
      COND_HAS2:     cond_true = status.has2;
      COND_DIV_MORE: cond_true = status.div_more;
      COND_OUT_BUSY: cond_true = status.out_busy;
      default:       cond_true = 1'b0;
    endcase
    if (cond_true) begin
      pc_d = ctrl.target;
    end else if (ctrl.last) begin
      pc_d = '0;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTHESIS
  a_fire_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (pc_q == PcW'(1)))
    else $error("accepted request did not start the program");

  a_pc_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < PcW'(UcodeLen))
    else $error("step counter left the microcode store");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.uop == UOP_EMIT && status.out_busy) |=> (ctrl.uop == UOP_EMIT))
    else $error("result step left while output register was occupied");
`endif

endmodule

### verif/park_miller_range_rng_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for park_miller_range_rng_unit: directed and random draw and reseed
// requests under several handshake pacing modes, checked against a built-in generator model.
// Depends on prmr_pkg and the park_miller_range_rng_unit RTL.

module park_miller_range_rng_unit_tb;
  import prmr_pkg::*;

  localparam logic        OpDraw      = 1'b0;
  localparam logic        OpSeed      = 1'b1;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned PhaseItems  = 210;

  typedef enum logic [1:0] {
    PACE_NONE,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_mode_e;

  typedef struct packed {
    logic             op;
    logic [DataW-1:0] first;
    logic [DataW-1:0] last;
    logic [DataW-1:0] seed;
  } rng_req_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             op_i           = OpDraw;
  logic [DataW-1:0] range_first_i  = '0;
  logic [DataW-1:0] range_last_i   = '0;
  logic [DataW-1:0] seed_value_i   = '0;
  logic             out_ready_i    = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [DataW-1:0] random_value_o;

  park_miller_range_rng_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .seed_value_i  (seed_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .random_value_o(random_value_o)
  );

  always #10 clk_i = ~clk_i;

  logic [DataW-1:0]   gen_state   = PmResetState;
  logic [DrawW-1:0]   spare_bits  = '0;
  logic [ResCntW-1:0] spare_count = '0;

  rng_req_t         pending_reqs[$];
  logic [DataW-1:0] expected_values[$];
  pace_mode_e       pace_mode     = PACE_NONE;
  int unsigned      error_count   = 0;
  int unsigned      checked_count = 0;
  int unsigned      draws_sent    = 0;
  int unsigned      seeds_sent    = 0;
  int unsigned      cycle_count   = 0;

  function automatic logic [DataW-1:0] next_lcg_value();
    logic [DataW-1:0] x;
    logic [63:0]      prod;
    x = (gen_state == '0) ? PmZeroSub : gen_state;
    prod = 64'(x) * 64'(PmMult);
    gen_state = DataW'(prod % 64'(PmMod));
    return gen_state;
  endfunction

  function automatic logic [5:0] take_spare_bits(input int unsigned nbits);
    logic [DataW-1:0] fill;
    logic [5:0]       got;
    if (spare_count < nbits) begin
      fill = next_lcg_value();
      spare_bits = fill[DrawW-1:0];
      spare_count = PmFillCount;
    end
    got = 6'(spare_bits & ((31'd1 << nbits) - 31'd1));
    spare_bits = spare_bits >> nbits;
    spare_count = spare_count - ResCntW'(nbits);
    return got;
  endfunction

  function automatic bit predict_request(input rng_req_t r, output logic [DataW-1:0] value);
    logic [DataW-1:0] span;
    logic [DataW-1:0] draw;
    logic [DataW-1:0] offset;
    logic [5:0]       spare;
    logic [63:0]      wide;
    value = '0;
    if (r.op == OpSeed) begin
      gen_state = r.seed;
      spare_bits = '0;
      spare_count = '0;
      return 1'b0;
    end
    span = r.last - r.first;
    if (span == PmFullSpan) begin
      draw = next_lcg_value();
      spare = take_spare_bits(PmTakeFull);
      offset = (draw >> 1) | (DataW'(spare[1:0]) << 30);
    end else if (span == PmExactSpan) begin
      offset = next_lcg_value();
    end else if (span < PmSmallLimit) begin
      draw = next_lcg_value();
      offset = (draw >> 1) % (span + 32'd1);
    end else begin
      draw = next_lcg_value();
      spare = take_spare_bits(PmTakeWide);
      wide = 64'(draw >> 1) | (64'(spare) << 30);
      offset = DataW'(wide % (64'(span) + 64'd1));
    end
    value = offset + r.first;
    return 1'b1;
  endfunction

  function automatic bit roll_idle(input bit sender_side);
    case (pace_mode)
      PACE_SENDER:   return sender_side && ($urandom_range(0, 99) < 80);
      PACE_RECEIVER: return !sender_side && ($urandom_range(0, 99) < 80);
      PACE_BOTH:     return $urandom_range(0, 99) < 12;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic rng_req_t draw_req(input logic [DataW-1:0] first,
                                        input logic [DataW-1:0] last);
    rng_req_t r;
    r.op = OpDraw;
    r.first = first;
    r.last = last;
    r.seed = $urandom;
    return r;
  endfunction

  function automatic rng_req_t seed_req(input logic [DataW-1:0] seed);
    rng_req_t r;
    r.op = OpSeed;
    r.first = $urandom;
    r.last = $urandom;
    r.seed = seed;
    return r;
  endfunction

  function automatic rng_req_t random_req();
    rng_req_t         r;
    logic [DataW-1:0] span;
    r = draw_req($urandom, $urandom);
    case ($urandom_range(0, 19))
      0: begin
        case ($urandom_range(0, 3))
          0:       r = seed_req('0);
          1:       r = seed_req({1'b0, PmMod});
          2:       r = seed_req($urandom | 32'h8000_0000);
          default: r = seed_req($urandom);
        endcase
      end
      1, 2, 3, 4: r.last = r.first - 32'd1;
      5, 6:       r.last = r.first + PmExactSpan;
      7, 8, 9, 10, 11: begin
        case ($urandom_range(0, 2))
          0:       span = $urandom_range(0, 15);
          1:       span = $urandom % PmSmallLimit;
          default: span = PmSmallLimit - 32'd1;
        endcase
        r.last = r.first + span;
      end
      12, 13, 14, 15, 16, 17: begin
        span = $urandom_range(PmFullSpan - 32'd1, PmSmallLimit);
        r.last = r.first + span;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_values.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    rng_req_t         req;
    logic [DataW-1:0] value;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        req.op = op_i;
        req.first = range_first_i;
        req.last = range_last_i;
        req.seed = seed_value_i;
        if (predict_request(req, value)) begin
          expected_values.push_back(value);
          draws_sent++;
        end else begin
          seeds_sent++;
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && !roll_idle(1'b1)) begin
          req = pending_reqs.pop_front();
          in_valid_i    <= 1'b1;
          op_i          <= req.op;
          range_first_i <= req.first;
          range_last_i  <= req.last;
          seed_value_i  <= req.seed;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    logic [DataW-1:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", random_value_o));
        end else begin
          want = expected_values.pop_front();
          checked_count++;
          if (random_value_o !== want) begin
            report_mismatch($sformatf("random_value got %h want %h", random_value_o, want));
          end
        end
      end
      out_ready_i <= !roll_idle(1'b0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    pace_mode_e mode;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Boundaries of every span class, wrapped ranges, and the special seeds.
    pending_reqs.push_back(draw_req(32'h0000_0000, 32'hffff_ffff));
    pending_reqs.push_back(draw_req(32'h0000_0000, 32'h7fff_fffe));
    pending_reqs.push_back(draw_req(32'hdead_beef, 32'hdead_beef));
    pending_reqs.push_back(draw_req(32'h0000_0000, 32'h07ff_fffe));
    pending_reqs.push_back(draw_req(32'h0000_0010, 32'h1000_000f));
    pending_reqs.push_back(draw_req(32'h0000_0001, 32'hffff_ffff));
    pending_reqs.push_back(draw_req(32'hffff_ff00, 32'h0000_0100));
    pending_reqs.push_back(draw_req(32'h8000_0000, 32'h7fff_ffff));
    pending_reqs.push_back(draw_req(32'hc000_0000, 32'h3fff_fffe));
    pending_reqs.push_back(draw_req(32'h0000_0000, 32'h7fff_ffff));
    pending_reqs.push_back(draw_req(32'h0000_0000, 32'h7fff_fffd));
    pending_reqs.push_back(seed_req(32'h0000_0000));
    pending_reqs.push_back(draw_req(32'h0000_0000, 32'h0000_0063));
    pending_reqs.push_back(seed_req(32'h7fff_ffff));
    pending_reqs.push_back(draw_req(32'h1234_5678, 32'h1234_5677));
    pending_reqs.push_back(draw_req(32'h0000_0000, 32'h8000_0000));
    pending_reqs.push_back(seed_req(32'hffff_ffff));
    pending_reqs.push_back(draw_req(32'hffff_ffff, 32'h7fff_fffd));
    pending_reqs.push_back(seed_req(32'h8000_0000));
    pending_reqs.push_back(draw_req(32'hffff_ffff, 32'hffff_0000));
    repeat (5) pending_reqs.push_back(draw_req($urandom, $urandom | 32'h8000_0000));
    wait_drained();

    // The sender holds off at each boundary until every result is back.
    for (int p = 0; p < 4; p++) begin
      mode = pace_mode_e'(p);
      pace_mode = mode;
      repeat (PhaseItems) pending_reqs.push_back(random_req());
      wait_drained();
    end
    pace_mode = PACE_NONE;
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d draw and %0d reseed requests and compared %0d results,",
             draws_sent, seeds_sent, checked_count);
    $display("covering all span classes under four pacing modes of both handshakes.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
